>>> design/hbsn_pkg.sv
// Shared types and constants for the HDLC bit stuffer with NRZI coder.
// Used by hbsn_ser, hbsn_nrzi and hdlc_bit_stuff_nrzi_encoder_top; no dependencies.
package hbsn_pkg;

    localparam int unsigned BITS_PER_BYTE = 8;
    localparam int unsigned IDX_W         = $clog2(BITS_PER_BYTE);
    localparam int unsigned RUN_W         = 3;
    localparam logic [RUN_W-1:0] RUN_LIMIT = RUN_W'(5);
    localparam logic [RUN_W-1:0] RUN_SAT   = RUN_W'(6);

    typedef struct packed {
        logic [BITS_PER_BYTE-1:0] data_byte;
        logic                     stuff_enable;
    } octet_t;

    typedef struct packed {
        logic line_level;
        logic inserted_zero;
        logic last_bit;
    } line_t;

    // one line bit offered by the serialiser to the coder
    typedef struct packed {
        logic valid;
        logic data_bit;
        logic stuffed;
        logic last;
    } bit_req_t;

    // coder status back to the serialiser
    typedef struct packed {
        logic ready;
        logic hit_limit;
    } coder_stat_t;

endpackage

>>> design/hbsn_ser.sv
// Byte serialiser: shifts a byte out LSB first, one line bit per cycle
// while ready, stuffing a zero after a run of five. Depends on hbsn_pkg.
module hbsn_ser
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  hbsn_pkg::octet_t    octet,
    input  hbsn_pkg::coder_stat_t stat,
    output hbsn_pkg::bit_req_t  req,
    output logic                busy
);

    localparam logic [hbsn_pkg::IDX_W-1:0] IDX_LAST =
        hbsn_pkg::IDX_W'(hbsn_pkg::BITS_PER_BYTE - 1);

    logic [hbsn_pkg::BITS_PER_BYTE-1:0] shift_reg, shift_next;
    logic [hbsn_pkg::IDX_W-1:0]         idx_reg, idx_next;
    logic                               busy_reg, busy_next;
    logic                               stuff_en_reg, stuff_en_next;
    logic                               pend_reg, pend_next;
    logic                               advance;
    logic                               hit;
    logic                               at_last;

    assign advance = busy_reg && stat.ready;
    assign at_last = (idx_reg == IDX_LAST);
    assign hit     = stuff_en_reg && !pend_reg && stat.hit_limit;

    always_comb
    begin
        req.valid    = busy_reg;
        req.data_bit = pend_reg ? 1'b0 : shift_reg[0];
        req.stuffed  = pend_reg;
        req.last     = at_last && !hit;
    end

    always_comb
    begin
        shift_next    = shift_reg;
        idx_next      = idx_reg;
        busy_next     = busy_reg;
        stuff_en_next = stuff_en_reg;
        pend_next     = pend_reg;
        if (load)
        begin
            shift_next    = octet.data_byte;
            idx_next      = '0;
            busy_next     = 1'b1;
            stuff_en_next = octet.stuff_enable;
            pend_next     = 1'b0;
        end
        else if (advance)
        begin
            if (hit)
            begin
                // hold position; the stuffed zero goes out next
                pend_next = 1'b1;
            end
            else
            begin
                pend_next = 1'b0;
                if (at_last)
                begin
                    busy_next = 1'b0;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    shift_next = shift_reg >> 1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            busy_reg     <= 1'b0;
            stuff_en_reg <= 1'b0;
            pend_reg     <= 1'b0;
        end
        else
        begin
            idx_reg      <= idx_next;
            busy_reg     <= busy_next;
            stuff_en_reg <= stuff_en_next;
            pend_reg     <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
    end

    assign busy = busy_reg;

    a_pend_busy: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> busy_reg)
        else $error("stuff pending while serialiser idle");

    a_no_double_stuff: assert property (@(posedge clk) disable iff (!rst_n)
        advance && pend_reg |=> !pend_reg)
        else $error("two stuffed zeros in a row");

    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && !stat.ready |=> $stable(req))
        else $error("line bit changed while held");

endmodule

>>> design/hbsn_nrzi.sv
// Run counter, NRZI level and output register for line bits.
// Depends on hbsn_pkg; fed by hbsn_ser.
module hbsn_nrzi
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  hbsn_pkg::bit_req_t    req,
    output hbsn_pkg::coder_stat_t stat,
    output logic                  line_valid,
    input  logic                  line_stall,
    output hbsn_pkg::line_t       line
);

    logic [hbsn_pkg::RUN_W-1:0] run_reg, run_next;
    logic                       level_reg, level_next;
    logic                       out_valid_reg, out_valid_next;
    hbsn_pkg::line_t            out_reg, out_next;
    logic                       ready;
    logic                       take;

    assign ready = !out_valid_reg || !line_stall;
    assign take  = req.valid && ready;

    // the offered bit brings the run to the stuffing limit
    assign stat.ready     = ready;
    assign stat.hit_limit = req.data_bit
                            && (run_reg == hbsn_pkg::RUN_LIMIT - hbsn_pkg::RUN_W'(1));

    always_comb
    begin
        run_next       = run_reg;
        level_next     = level_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && line_stall;
        if (take)
        begin
            if (req.data_bit)
            begin
                if (run_reg != hbsn_pkg::RUN_SAT)
                begin
                    run_next = run_reg + 1'b1;
                end
            end
            else
            begin
                run_next   = '0;
                level_next = !level_reg;
            end
            out_next.line_level    = level_next;
            out_next.inserted_zero = req.stuffed;
            out_next.last_bit      = req.last;
            out_valid_next         = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg       <= '0;
            level_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            run_reg       <= run_next;
            level_reg     <= level_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign line_valid = out_valid_reg;
    assign line       = out_reg;

    a_run_sat: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg <= hbsn_pkg::RUN_SAT)
        else $error("ones run beyond saturation");

    a_stuff_zero: assert property (@(posedge clk) disable iff (!rst_n)
        take && req.stuffed |-> !req.data_bit)
        else $error("stuffed beat is not a zero");

    a_stuff_clears: assert property (@(posedge clk) disable iff (!rst_n)
        take && req.stuffed |=> run_reg == '0 && level_reg != $past(level_reg))
        else $error("stuffed zero did not clear run and toggle level");

endmodule

>>> design/hdlc_bit_stuff_nrzi_encoder_top.sv
// HDLC bit stuffer with NRZI line coding. Takes one byte per beat and sends
// its bits LSB first, one line bit per clock while the line side does not
// stall, adding a zero after five ones when stuffing is on. A byte gives 8
// to 10 line beats; the serialiser first loads its shift register, then
// sends one line bit per line beat. A new byte is taken the cycle after the
// previous byte's last line bit has entered the output register. Depends on
// hbsn_pkg, hbsn_ser and hbsn_nrzi.
module hdlc_bit_stuff_nrzi_encoder_top
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             octet_valid,
    output logic             octet_stall,
    input  hbsn_pkg::octet_t octet,
    output logic             line_valid,
    input  logic             line_stall,
    output hbsn_pkg::line_t  line
);

    hbsn_pkg::bit_req_t    req;
    hbsn_pkg::coder_stat_t stat;
    logic                  busy;
    logic                  load;

    assign octet_stall = busy;
    assign load        = octet_valid && !busy;

    hbsn_ser u_ser
    (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (load),
        .octet (octet),
        .stat  (stat),
        .req   (req),
        .busy  (busy)
    );

    hbsn_nrzi u_nrzi
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .stat       (stat),
        .line_valid (line_valid),
        .line_stall (line_stall),
        .line       (line)
    );

endmodule

>>> tb/testbench.sv
// Self-checking testbench for hdlc_bit_stuff_nrzi_encoder_top: bytes in, NRZI line bits out.
// Needs hbsn_pkg for the beat types; expected line bits come from an in-bench stuffer/coder.
`timescale 1ns / 100ps

module testbench;

    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int unsigned TAIL_CYCLES = 24;
    localparam logic [7:0]  HDLC_FLAG   = 8'h7E;

    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             octet_valid = 1'b0;
    logic             octet_stall;
    hbsn_pkg::octet_t octet       = '0;
    logic             line_valid;
    logic             line_stall  = 1'b0;
    hbsn_pkg::line_t  line;

    // Copy of the coder state for prediction
    logic [hbsn_pkg::RUN_W-1:0] run_ones  = '0;
    logic                       nrzi_lvl  = 1'b0;
    hbsn_pkg::line_t            line_due[$];

    int unsigned tx_idle_pct   = 0;
    int unsigned rx_idle_pct   = 0;
    int unsigned hold_req      = 0;
    int unsigned hold_left     = 0;
    int unsigned mismatches    = 0;
    int unsigned cycle_count   = 0;

    hdlc_bit_stuff_nrzi_encoder_top dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .octet_valid (octet_valid),
        .octet_stall (octet_stall),
        .octet       (octet),
        .line_valid  (line_valid),
        .line_stall  (line_stall),
        .line        (line)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver back-pressure: a requested hold-off wins over random stalls
    always @(posedge clk)
    begin
        if (hold_req != 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left != 0)
        begin
            line_stall <= 1'b1;
            hold_left  = hold_left - 1;
        end
        else
        begin
            line_stall <= ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    // Compare each accepted line beat with the oldest expected one
    always @(posedge clk)
    begin
        hbsn_pkg::line_t want;
        if (rst_n && line_valid && !line_stall)
        begin
            if (line_due.size() == 0)
            begin
                $error("line beat with nothing expected: %b", line);
                mismatches++;
            end
            else
            begin
                want = line_due.pop_front();
                if (line.line_level !== want.line_level)
                begin
                    $error("line_level: expected %b, got %b", want.line_level, line.line_level);
                    mismatches++;
                end
                if (line.inserted_zero !== want.inserted_zero)
                begin
                    $error("inserted_zero: expected %b, got %b",
                           want.inserted_zero, line.inserted_zero);
                    mismatches++;
                end
                if (line.last_bit !== want.last_bit)
                begin
                    $error("last_bit: expected %b, got %b", want.last_bit, line.last_bit);
                    mismatches++;
                end
            end
        end
    end

    function automatic hbsn_pkg::line_t code_bit(input logic data_bit, input logic stuffed);
        hbsn_pkg::line_t b;
        if (data_bit)
        begin
            if (run_ones < hbsn_pkg::RUN_SAT)
                run_ones = run_ones + 1'b1;
        end
        else
        begin
            run_ones = '0;
            nrzi_lvl = ~nrzi_lvl;
        end
        b.line_level    = nrzi_lvl;
        b.inserted_zero = stuffed;
        b.last_bit      = 1'b0;
        return b;
    endfunction

    // Queue the line bits one byte produces, zero inserted after a run of five when stuffing is on
    task automatic predict_line_bits(input hbsn_pkg::octet_t o);
        hbsn_pkg::line_t bits[$];
        for (int i = 0; i < hbsn_pkg::BITS_PER_BYTE; i++)
        begin
            bits.push_back(code_bit(o.data_byte[i], 1'b0));
            if (o.stuff_enable && run_ones == hbsn_pkg::RUN_LIMIT)
                bits.push_back(code_bit(1'b0, 1'b1));
        end
        bits[bits.size() - 1].last_bit = 1'b1;
        foreach (bits[i])
            line_due.push_back(bits[i]);
    endtask

    // Offer one byte beat and hold it until taken; valid stays high on return
    task automatic send_octet(input logic [7:0] data_byte, input logic stuff_enable);
        hbsn_pkg::octet_t o;
        o.data_byte    = data_byte;
        o.stuff_enable = stuff_enable;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            octet_valid <= 1'b0;
            @(posedge clk);
        end
        octet_valid <= 1'b1;
        octet       <= o;
        @(posedge clk);
        while (octet_stall)
            @(posedge clk);
        predict_line_bits(o);
    endtask

    task automatic drain_line;
        octet_valid <= 1'b0;
        while (line_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_extremes;
        send_octet(8'h00, 1'b0);
        send_octet(8'h00, 1'b1);
        send_octet(8'hFF, 1'b1);
        send_octet(8'h1F, 1'b1);
        send_octet(8'hAA, 1'b1);
        send_octet(8'h55, 1'b0);
        send_octet(HDLC_FLAG, 1'b0);
        drain_line();
    endtask

    // Run of ones left across a byte boundary gives two inserted zeros
    task automatic test_double_insert;
        send_octet(8'hF0, 1'b1);
        send_octet(8'hFF, 1'b1);
        send_octet(8'hF0, 1'b1);
        send_octet(8'h00, 1'b1);
        drain_line();
    endtask

    // Unstuffed ones saturate the counter; stuffed ones after it insert nothing
    task automatic test_saturation;
        send_octet(8'hFF, 1'b0);
        send_octet(8'h01, 1'b1);
        send_octet(8'hFE, 1'b1);
        send_octet(8'hF8, 1'b0);
        send_octet(8'h01, 1'b1);
        send_octet(8'h1F, 1'b1);
        send_octet(8'hFF, 1'b0);
        send_octet(8'hFF, 1'b1);
        drain_line();
    endtask

    function automatic logic [7:0] payload_byte;
        case ($urandom_range(0, 4))
            0:       return 8'hFF;
            1:       return 8'($urandom_range(0, 255) | $urandom_range(0, 255));
            2:       return 8'($urandom_range(0, 255) | $urandom_range(0, 255)
                               | $urandom_range(0, 255));
            3:       return 8'($urandom_range(0, 255) & $urandom_range(0, 255));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly flag-delimited frames with stuffed payload, some ending in an abort; the rest noise
    task automatic test_random_traffic(input int unsigned n_items);
        int unsigned sent;
        int unsigned len;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                len = $urandom_range(1, 6);
                send_octet(HDLC_FLAG, 1'b0);
                for (int i = 0; i < len; i++)
                    send_octet(payload_byte(), 1'b1);
                if ($urandom_range(0, 7) == 0)
                    send_octet(8'hFF, 1'b0);
                else
                    send_octet(HDLC_FLAG, 1'b0);
                sent += len + 2;
            end
            else
            begin
                send_octet(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                sent++;
            end
        end
        drain_line();
    endtask

    // Hold the line side off long enough for the input to back up
    task automatic test_backpressure;
        hold_req = 300;
        for (int i = 0; i < 8; i++)
            send_octet(payload_byte(), 1'b1);
        drain_line();
        send_octet(8'hFF, 1'b1);
        drain_line();
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 11;
        rx_idle_pct = 54;
        test_extremes();
        test_double_insert();
        test_saturation();
        test_random_traffic(160);
        test_backpressure();

        tx_idle_pct = 54;
        rx_idle_pct = 11;
        test_random_traffic(160);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_traffic(160);

        drain_line();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && line_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> sim.f
design/hbsn_pkg.sv
design/hbsn_ser.sv
design/hbsn_nrzi.sv
design/hdlc_bit_stuff_nrzi_encoder_top.sv
tb/testbench.sv
